FILE: rtl/core/sfcc_pkg.sv
// ----------------------------------------------------------------------------
// sfcc_pkg
// Shared constants and types of the sensor frame CRC checker.
// ----------------------------------------------------------------------------
package sfcc_pkg;

	localparam int unsigned POS_W = 4;

	localparam logic [POS_W-1:0] POS_CRC_LO = 4'd6;
	localparam logic [POS_W-1:0] POS_LAST   = 4'd7;
	localparam logic [POS_W-1:0] POS_IDLE   = 4'd8;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  FUNC_CODE  = 8'h03;
	localparam logic [7:0]  BYTE_COUNT = 8'h04;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_HEADER = 2'd1;
	localparam logic [1:0] ST_BAD_CRC    = 2'd2;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        humidity_tenths;
		logic signed [15:0] temperature_tenths;
	} sfcc_result_t;

	// CRC register control from the frame tracker
	typedef struct packed {
		logic       step;
		logic       restart;
		logic [7:0] data;
	} sfcc_crc_ctrl_t;

endpackage

FILE: rtl/core/sfcc_byte_if.sv
// ----------------------------------------------------------------------------
// sfcc_byte_if
// Byte request channel: one response byte with its frame start flag.
// ----------------------------------------------------------------------------
interface sfcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

FILE: rtl/core/sfcc_result_if.sv
// ----------------------------------------------------------------------------
// sfcc_result_if
// Result request channel: frame status, humidity and temperature.
// ----------------------------------------------------------------------------
interface sfcc_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [15:0]        humidity_tenths;
	logic signed [15:0] temperature_tenths;

	modport source (output valid, output status, output humidity_tenths,
		output temperature_tenths, input ready);
	modport sink   (input valid, input status, input humidity_tenths,
		input temperature_tenths, output ready);
endinterface

FILE: rtl/core/sfcc_crc_unit.sv
// ----------------------------------------------------------------------------
// sfcc_crc_unit
// Running reflected CRC-16 register, one byte folded in per cycle while step is high.
// ----------------------------------------------------------------------------
module sfcc_crc_unit
	import sfcc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  sfcc_crc_ctrl_t ctrl,
	output logic [15:0]    crc
);

	logic [15:0] crc_q;
	logic [15:0] crc_base;
	logic [15:0] crc_next;

	// eight bit steps of the reflected polynomial
	always_comb begin
		crc_base = ctrl.restart ? CRC_INIT : crc_q;
		crc_next = crc_base ^ {8'h00, ctrl.data};
		for (int k = 0; k < 8; k++) begin
			if (crc_next[0]) begin
				crc_next = (crc_next >> 1) ^ CRC_POLY;
			end else begin
				crc_next = crc_next >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.step) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;

endmodule

FILE: rtl/core/sfcc_frame_tracker.sv
// ----------------------------------------------------------------------------
// sfcc_frame_tracker
// Byte position, header check, data capture and the end-of-frame verdict.
// ----------------------------------------------------------------------------
module sfcc_frame_tracker
	import sfcc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic [7:0]     rx_byte,
	input  logic           frame_start,
	input  logic [15:0]    crc,
	output sfcc_crc_ctrl_t crc_ctrl,
	output logic           res_valid,
	output sfcc_result_t   res
);

	logic [POS_W-1:0] pos_q;
	logic             header_good_q;
	logic [15:0]      hum_q;
	logic [15:0]      temp_q;
	logic [7:0]       crc_lo_q;

	logic [POS_W-1:0] pos_eff;
	logic             active;
	logic             header_next;
	logic [15:0]      rx_crc;
	logic [15:0]      mag;

	assign pos_eff = frame_start ? '0 : pos_q;
	assign active  = frame_start || (pos_q < POS_IDLE);

	always_comb begin
		header_next = header_good_q;
		if (pos_eff == 4'd0) begin
			header_next = (rx_byte == FUNC_CODE);
		end else if (pos_eff == 4'd1) begin
			header_next = header_good_q && (rx_byte == BYTE_COUNT);
		end
	end

	assign crc_ctrl.step    = advance && active && (pos_eff < POS_CRC_LO);
	assign crc_ctrl.restart = frame_start;
	assign crc_ctrl.data    = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (advance && active) begin
			pos_q <= (pos_eff == POS_LAST) ? POS_IDLE : pos_eff + 4'd1;
		end
	end

	// capture payload bytes; big-endian data words
	always_ff @(posedge clk) begin
		if (advance && active) begin
			header_good_q <= header_next;
			unique case (pos_eff)
				4'd2:       hum_q[15:8]  <= rx_byte;
				4'd3:       hum_q[7:0]   <= rx_byte;
				4'd4:       temp_q[15:8] <= rx_byte;
				4'd5:       temp_q[7:0]  <= rx_byte;
				POS_CRC_LO: crc_lo_q     <= rx_byte;
				default: begin
				end
			endcase
		end
	end

	// verdict on the eighth byte; sign-magnitude to two's complement
	assign rx_crc    = {rx_byte, crc_lo_q};
	assign mag       = {1'b0, temp_q[14:0]};
	assign res_valid = active && (pos_eff == POS_LAST);

	always_comb begin
		res.status             = ST_OK;
		res.humidity_tenths    = '0;
		res.temperature_tenths = '0;
		priority if (!header_good_q) begin
			res.status = ST_BAD_HEADER;
		end else if (rx_crc != crc) begin
			res.status = ST_BAD_CRC;
		end else begin
			res.humidity_tenths    = hum_q;
			res.temperature_tenths = temp_q[15] ? -$signed(mag) : $signed(mag);
		end
	end

endmodule

FILE: rtl/core/sensor_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_checker
// Checks an eight-byte sensor response: header, CRC-16 and data conversion.
// ----------------------------------------------------------------------------
// Result path: the verdict on the eighth byte goes from the input register into
// the result register, which loads it when the register is free or drained.
// Throughput: one byte per cycle while the result register is not stalled, set
// by the combinational eight-step CRC update between the input register and the result register.
// Reset: arst_n clears both handshake stages and parks the byte position at
// idle, so bytes without a start flag are dropped until a frame begins.
// ----------------------------------------------------------------------------
module sensor_frame_crc_checker
	import sfcc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	sfcc_byte_if.sink     frame_bytes,
	sfcc_result_if.source frame_result
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// result register
	logic         out_valid_q;
	sfcc_result_t out_q;

	logic           advance_s1;
	logic           res_valid;
	sfcc_result_t   res;
	sfcc_crc_ctrl_t crc_ctrl;
	logic [15:0]    crc;

	// Advance the input stage whenever the result register is free or being
	// drained; bytes that give no result move on regardless of the output.
	assign advance_s1        = valid_s1 && (!res_valid || !out_valid_q || frame_result.ready);
	assign frame_bytes.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_bytes.ready) begin
			valid_s1 <= frame_bytes.valid;
		end
	end

	// hold the captured byte while the stage waits
	always_ff @(posedge clk) begin
		if (frame_bytes.ready && frame_bytes.valid) begin
			byte_s1  <= frame_bytes.rx_byte;
			start_s1 <= frame_bytes.frame_start;
		end
	end

	sfcc_frame_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance_s1),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.crc         (crc),
		.crc_ctrl    (crc_ctrl),
		.res_valid   (res_valid),
		.res         (res)
	);

	sfcc_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.crc    (crc)
	);

	// Load a new result on the advancing eighth byte; drop the old one once
	// the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (frame_result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign frame_result.valid              = out_valid_q;
	assign frame_result.status             = out_q.status;
	assign frame_result.humidity_tenths    = out_q.humidity_tenths;
	assign frame_result.temperature_tenths = out_q.temperature_tenths;

	// Back-pressure on bytes comes only from a stalled result.
	a_ready_source: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_bytes.ready |->
		(valid_s1 && res_valid && out_valid_q && !frame_result.ready))
		else $error("byte channel stalled without a stalled result");

	// A new result always comes from a byte held in the input stage.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a byte in the input stage");

	// Failed frames carry zero data.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != ST_OK)) |->
		((out_q.humidity_tenths == 16'd0) && (out_q.temperature_tenths == 16'sd0)))
		else $error("failed frame carries nonzero data");

	// Status code never takes the unused value.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.status == ST_OK) || (out_q.status == ST_BAD_HEADER) ||
		(out_q.status == ST_BAD_CRC)))
		else $error("result status out of range");

endmodule

FILE: tb/tb_sensor_frame_crc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_crc_checker
// Self-checking bench for the sensor frame CRC checker. A short scripted
// sequence covers header faults, abandoned frames, stray bytes and the
// temperature sign cases. Random frames with random content, CRC faults and
// noise follow. Each result is compared with a bit-true bench tracker or
// a scripted frame's typed-in result. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_sensor_frame_crc_checker;
	import sfcc_pkg::*;

	localparam int unsigned ITEM_TARGET  = 700;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned HOLD_AT      = 30;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned FRAME_BYTES  = 8;
	localparam int unsigned SCRIPT_LEN   = 28;

	localparam sfcc_result_t NO_RESULT = '0;

	// How a scripted byte gets its value: as written, or from the CRC of the
	// frame bytes sent since the last start flag.
	typedef enum logic [1:0] {
		FILL_NONE,
		FILL_CRC_LO,
		FILL_CRC_HI,
		FILL_CRC_BAD
	} fill_t;

	typedef struct {
		logic [7:0]   data;
		logic         start;
		fill_t        fill;
		logic         pinned;
		sfcc_result_t want;
	} script_row_t;

	logic clk;
	logic arst_n;

	sfcc_byte_if   byte_ch ();
	sfcc_result_if res_ch ();

	sensor_frame_crc_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_bytes  (byte_ch),
		.frame_result (res_ch)
	);

	// Side band that travels with each byte request: a typed-in result that
	// replaces the tracked one when the request completes a frame.
	logic         pin_on;
	sfcc_result_t pin_res;

	// Frame tracker state
	logic [3:0]  trk_pos;
	logic [15:0] trk_crc;
	logic        trk_hdr_ok;
	logic [15:0] trk_hum;
	logic [15:0] trk_temp;
	logic [7:0]  trk_crc_lo;

	sfcc_result_t pending_frames[$];

	int unsigned mismatches;
	int unsigned frame_bytes_sent;
	logic        calm;

	// Scripted part. Only rows that close a frame carry a typed-in result.
	script_row_t script [SCRIPT_LEN] = '{
		// idle after reset: drop
		'{8'hA5,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		// extreme values: humidity all ones, most negative temperature
		'{FUNC_CODE,  1'b1, FILL_NONE,    1'b0, NO_RESULT},
		'{BYTE_COUNT, 1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'hFF,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'hFF,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'hFF,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'hFF,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'h00,      1'b0, FILL_CRC_LO,  1'b0, NO_RESULT},
		'{8'h00,      1'b0, FILL_CRC_HI,  1'b1, '{ST_OK, 16'hFFFF, 16'sh8001}},
		// past the eighth byte: drop
		'{8'h5A,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		// abandoned frame, restarted by the next start flag
		'{FUNC_CODE,  1'b1, FILL_NONE,    1'b0, NO_RESULT},
		'{BYTE_COUNT, 1'b0, FILL_NONE,    1'b0, NO_RESULT},
		// negative zero temperature, zero humidity
		'{FUNC_CODE,  1'b1, FILL_NONE,    1'b0, NO_RESULT},
		'{BYTE_COUNT, 1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'h00,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'h00,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'h80,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'h00,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'h00,      1'b0, FILL_CRC_LO,  1'b0, NO_RESULT},
		'{8'h00,      1'b0, FILL_CRC_HI,  1'b1, '{ST_OK, 16'h0000, 16'sh0000}},
		// header and CRC both bad: header fault wins, data fields zero
		'{8'h00,      1'b1, FILL_NONE,    1'b0, NO_RESULT},
		'{8'h05,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'h12,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'h34,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'h7F,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'hFF,      1'b0, FILL_NONE,    1'b0, NO_RESULT},
		'{8'h00,      1'b0, FILL_CRC_LO,  1'b0, NO_RESULT},
		'{8'h00,      1'b0, FILL_CRC_BAD, 1'b1, '{ST_BAD_HEADER, 16'h0000, 16'sh0000}}
	};

	// Reflected CRC-16, one byte, eight shift steps
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Advance the frame tracker by one accepted byte; queue a result when the
	// byte closes a frame.
	task automatic track_frame_byte(input logic [7:0] b, input logic s, input logic pin,
		input sfcc_result_t pinned_res);
		sfcc_result_t res;
		logic [15:0]  rx_crc;
		if (s) begin
			trk_pos    = '0;
			trk_crc    = CRC_INIT;
			trk_hdr_ok = 1'b1;
		end else if (trk_pos >= POS_IDLE) begin
			return;
		end

		case (trk_pos)
			4'd0: trk_hdr_ok = (b == FUNC_CODE);
			4'd1: trk_hdr_ok = trk_hdr_ok && (b == BYTE_COUNT);
			4'd2: trk_hum[15:8] = b;
			4'd3: trk_hum[7:0] = b;
			4'd4: trk_temp[15:8] = b;
			4'd5: trk_temp[7:0] = b;
			POS_CRC_LO: trk_crc_lo = b;
			default: ;
		endcase

		if (trk_pos < POS_CRC_LO) begin
			trk_crc = crc16_step(trk_crc, b);
			trk_pos = trk_pos + 4'd1;
		end else if (trk_pos == POS_CRC_LO) begin
			trk_pos = trk_pos + 4'd1;
		end else begin
			// eighth byte carries the CRC high byte
			rx_crc  = {b, trk_crc_lo};
			trk_pos = POS_IDLE;
			res     = NO_RESULT;
			if (!trk_hdr_ok) begin
				res.status = ST_BAD_HEADER;
			end else if (rx_crc != trk_crc) begin
				res.status = ST_BAD_CRC;
			end else begin
				res.status          = ST_OK;
				res.humidity_tenths = trk_hum;
				// sign-magnitude to two's complement; negative zero folds to zero
				if (trk_temp[15])
					res.temperature_tenths = 16'h0000 - {1'b0, trk_temp[14:0]};
				else
					res.temperature_tenths = {1'b0, trk_temp[14:0]};
			end
			pending_frames.push_back(pin ? pinned_res : res);
		end
	endtask

	// Offer one byte request after a random gap and hold it until accepted.
	task automatic push_byte(input logic [7:0] b, input logic s, input logic pin,
		input sfcc_result_t pres);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.rx_byte     <= b;
		byte_ch.frame_start <= s;
		pin_on              <= pin;
		pin_res             <= pres;
		do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
	endtask

	// One random frame: mostly well formed, sometimes with a bad header, a
	// flipped CRC bit, a cut before the end, or stray bytes behind it.
	task automatic send_random_frame();
		logic [7:0]  fb [FRAME_BYTES];
		logic [15:0] crc;
		logic [15:0] hum;
		logic [15:0] temp;
		int          cut;
		hum = 16'($urandom);
		case ($urandom_range(0, 9))
			0: temp = 16'h8000;
			1: temp = 16'h7FFF;
			2: temp = 16'hFFFF;
			3: temp = 16'h0000;
			default: temp = 16'($urandom);
		endcase
		fb[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FUNC_CODE;
		fb[1] = ($urandom_range(0, 11) == 0) ? 8'($urandom) : BYTE_COUNT;
		fb[2] = hum[15:8];
		fb[3] = hum[7:0];
		fb[4] = temp[15:8];
		fb[5] = temp[7:0];
		crc = CRC_INIT;
		for (int k = 0; k < 6; k++)
			crc = crc16_step(crc, fb[k]);
		if ($urandom_range(0, 7) == 0)
			crc = crc ^ (16'h0001 << $urandom_range(0, 15));
		fb[6] = crc[7:0];
		fb[7] = crc[15:8];

		cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 7) : FRAME_BYTES;
		for (int k = 0; k < cut; k++) begin
			push_byte(fb[k], k == 0, 1'b0, NO_RESULT);
			frame_bytes_sent++;
		end

		case ($urandom_range(0, 9))
			// trailing bytes without a start flag
			0, 1: repeat ($urandom_range(1, 3))
				push_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
			// noise with occasional start flags
			2: repeat ($urandom_range(1, 6)) begin
				push_byte(8'($urandom), $urandom_range(0, 4) == 0, 1'b0, NO_RESULT);
				frame_bytes_sent++;
			end
			default: ;
		endcase
	endtask

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if it hangs
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Track every accepted byte request
	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready)
			track_frame_byte(byte_ch.rx_byte, byte_ch.frame_start, pin_on, pin_res);
	end

	// Compare every accepted result request with the oldest pending frame
	always @(posedge clk) begin
		sfcc_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_frames.size() == 0) begin
				$error("result with no frame pending: status %0d humidity %0d temperature %0d",
					res_ch.status, res_ch.humidity_tenths, res_ch.temperature_tenths);
				mismatches++;
			end else begin
				want = pending_frames.pop_front();
				if (res_ch.status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						want.status, res_ch.status);
					mismatches++;
				end
				if (res_ch.humidity_tenths !== want.humidity_tenths) begin
					$error("humidity_tenths mismatch: expected %0d, actual %0d",
						want.humidity_tenths, res_ch.humidity_tenths);
					mismatches++;
				end
				if (res_ch.temperature_tenths !== want.temperature_tenths) begin
					$error("temperature_tenths mismatch: expected %0d, actual %0d",
						want.temperature_tenths, res_ch.temperature_tenths);
					mismatches++;
				end
			end
		end
	end

	// Result side: random hold-off per request, one long hold once the block
	// has delivered a few dozen results, none during calm stretches.
	initial begin
		int gap;
		int taken;
		taken        = 0;
		res_ch.ready = 1'b0;
		forever begin
			if (taken == HOLD_AT)
				gap = LONG_HOLD;
			else if (calm)
				gap = 0;
			else
				gap = $urandom_range(0, 7);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
			taken++;
		end
	end

	// Stimulus
	initial begin
		logic [15:0] walk_crc;
		logic [7:0]  b;
		logic        paused;

		byte_ch.valid       = 1'b0;
		byte_ch.rx_byte     = '0;
		byte_ch.frame_start = 1'b0;
		pin_on              = 1'b0;
		pin_res             = NO_RESULT;
		calm                = 1'b0;
		paused              = 1'b0;
		mismatches          = 0;
		frame_bytes_sent    = 0;
		walk_crc            = CRC_INIT;

		// tracker starts idle, like the block after reset
		trk_pos    = POS_IDLE;
		trk_crc    = CRC_INIT;
		trk_hdr_ok = 1'b1;
		trk_hum    = '0;
		trk_temp   = '0;
		trk_crc_lo = '0;

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the script; CRC rows take their value from the running CRC of
		// the bytes sent since the last start flag.
		foreach (script[i]) begin
			if (script[i].start)
				walk_crc = CRC_INIT;
			case (script[i].fill)
				FILL_CRC_LO:  b = walk_crc[7:0];
				FILL_CRC_HI:  b = walk_crc[15:8];
				FILL_CRC_BAD: b = ~walk_crc[15:8];
				default: begin
					b        = script[i].data;
					walk_crc = crc16_step(walk_crc, b);
				end
			endcase
			push_byte(b, script[i].start, script[i].pinned, script[i].want);
		end

		// Random frames; toggle calm stretches now and then, and pause once
		// halfway until every pending frame has come back.
		while (frame_bytes_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 7) == 0)
				calm = ~calm;
			if (!paused && frame_bytes_sent >= ITEM_TARGET / 2) begin
				paused = 1'b1;
				byte_ch.valid <= 1'b0;
				do @(posedge clk); while (pending_frames.size() != 0);
			end
			send_random_frame();
		end
		byte_ch.valid <= 1'b0;

		// Drain: wait for every pending frame, then keep watching the result channel
		// to catch anything extra the block might still emit.
		do @(posedge clk); while (pending_frames.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
